@@ hw/rtl/easing_curve_interpolator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Easing curve interpolator assertion macros
// Shared property macros for the interpolator's internal checks.
// ----------------------------------------------------------------------------
`ifndef EASING_CURVE_INTERPOLATOR_TOP_DEFINES_SVH
`define EASING_CURVE_INTERPOLATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent.
`define ECINT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define ECINT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ECINT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ECINT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/ecint_pkg.sv @@
// ----------------------------------------------------------------------------
// Easing curve interpolator package
// Default widths, queue depth and curve family codes.
// ----------------------------------------------------------------------------
package ecint_pkg;

    localparam int VALUE_BITS_DEF    = 32;
    localparam int FRAME_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;

    // Curve families. Linear runs as ease-in with a power of one.
    localparam logic [1:0] KIND_IN    = 2'd0;
    localparam logic [1:0] KIND_OUT   = 2'd1;
    localparam logic [1:0] KIND_INOUT = 2'd2;

    localparam logic [3:0] MODE_IN_FIRST    = 4'd1;
    localparam logic [3:0] MODE_IN_LAST     = 4'd4;
    localparam logic [3:0] MODE_OUT_FIRST   = 4'd5;
    localparam logic [3:0] MODE_OUT_LAST    = 4'd8;
    localparam logic [3:0] MODE_INOUT_FIRST = 4'd9;
    localparam logic [3:0] MODE_INOUT_LAST  = 4'd12;

endpackage

@@ hw/rtl/ecint_front.sv @@
// ----------------------------------------------------------------------------
// Easing curve interpolator front end
// Accepts input beats, classifies the mode and prepares the value span.
// ----------------------------------------------------------------------------
module ecint_front #(
    parameter int VALUE_BITS    = ecint_pkg::VALUE_BITS_DEF,
    parameter int FRAME_BITS    = ecint_pkg::FRAME_BITS_DEF,
    parameter int IN_BYTES_BITS = 8,
    parameter int ITEM_BITS     = 8
) (
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_BYTES_BITS-1:0] s_tdata,
    input  logic [3:0]               s_tuser,
    output logic                     push,
    output logic [ITEM_BITS-1:0]     push_item,
    input  logic                     full
);

    typedef struct packed {
        logic [1:0]            kind;
        logic [2:0]            n;
        logic                  clamped;
        logic                  ge;
        logic                  neg;
        logic [VALUE_BITS-1:0] s;
        logic [VALUE_BITS:0]   m;
        logic [FRAME_BITS-1:0] fr;
        logic [FRAME_BITS-1:0] du;
    } item_t;

    item_t                 item;
    logic [VALUE_BITS-1:0] start_v;
    logic [VALUE_BITS-1:0] end_v;
    logic [VALUE_BITS:0]   diff;
    logic [3:0]            mode;

    assign start_v = s_tdata[VALUE_BITS-1:0];
    assign end_v   = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
    assign mode    = s_tuser;
    assign diff    = {end_v[VALUE_BITS-1], end_v} - {start_v[VALUE_BITS-1], start_v};

    always_comb
    begin
        item.fr      = s_tdata[2*VALUE_BITS+FRAME_BITS-1:2*VALUE_BITS];
        item.du      = s_tdata[2*VALUE_BITS+2*FRAME_BITS-1:2*VALUE_BITS+FRAME_BITS];
        item.clamped = item.fr > item.du;
        item.ge      = item.fr >= item.du;
        item.s       = start_v;
        item.neg     = diff[VALUE_BITS];
        item.m       = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;
        item.kind    = ecint_pkg::KIND_IN;
        item.n       = 3'd1;
        if (mode >= ecint_pkg::MODE_IN_FIRST && mode <= ecint_pkg::MODE_IN_LAST)
        begin
            item.n = 3'(mode + 4'd1);
        end
        else if (mode >= ecint_pkg::MODE_OUT_FIRST && mode <= ecint_pkg::MODE_OUT_LAST)
        begin
            item.kind = ecint_pkg::KIND_OUT;
            item.n    = 3'(mode - 4'd3);
        end
        else if (mode >= ecint_pkg::MODE_INOUT_FIRST && mode <= ecint_pkg::MODE_INOUT_LAST)
        begin
            item.kind = ecint_pkg::KIND_INOUT;
            item.n    = 3'(mode - 4'd7);
        end
    end

    assign s_tready  = !full;
    assign push      = s_tvalid && !full;
    assign push_item = item;

endmodule

@@ hw/rtl/ecint_queue.sv @@
// ----------------------------------------------------------------------------
// Easing curve interpolator queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module ecint_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ecint_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/ecint_back.sv @@
// ----------------------------------------------------------------------------
// Easing curve interpolator back end
// Pipelined divider, power chain, curve shaping and final blend.
// ----------------------------------------------------------------------------
module ecint_back #(
    parameter int VALUE_BITS    = ecint_pkg::VALUE_BITS_DEF,
    parameter int FRAME_BITS    = ecint_pkg::FRAME_BITS_DEF,
    parameter int FRACTION_BITS = ecint_pkg::FRACTION_BITS_DEF,
    parameter int ITEM_BITS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  logic [ITEM_BITS-1:0]  head_item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] out_value,
    output logic                  out_clamped
);

    localparam int V  = VALUE_BITS;
    localparam int FW = FRAME_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int NS = F + 9;
    localparam logic [F:0] ONE  = (F+1)'(1) << F;

    typedef struct packed {
        logic [1:0]    kind;
        logic [2:0]    n;
        logic          clamped;
        logic          ge;
        logic          neg;
        logic [V-1:0]  s;
        logic [V:0]    m;
        logic [FW-1:0] fr;
        logic [FW-1:0] du;
    } item_t;

    typedef struct packed {
        logic [1:0]    kind;
        logic [2:0]    n;
        logic          clamped;
        logic          ge;
        logic          neg;
        logic [V-1:0]  s;
        logic [V:0]    m;
        logic [FW-1:0] du;
        logic [FW-1:0] rem;
        logic [F-1:0]  q;
        logic          low;
        logic [F:0]    x;
        logic [F:0]    p;
        logic [F:0]    f;
        logic [V+1:0]  hi;
        logic [2*F:0]  lo;
        logic [V:0]    mag;
        logic [V-1:0]  res;
    } stage_t;

    item_t        head;
    stage_t       cur [NS];
    stage_t       nxt [NS];
    stage_t       pipe_reg [NS];
    logic [NS-1:0] vld_reg;
    logic          advance;

    assign head = head_item;

    // The whole pipe moves together unless the last beat is held.
    assign advance = !vld_reg[NS-1] || out_ready;
    assign pop     = advance && head_valid;

    always_comb
    begin
        cur[0]         = '0;
        cur[0].kind    = head.kind;
        cur[0].n       = head.n;
        cur[0].clamped = head.clamped;
        cur[0].ge      = head.ge;
        cur[0].neg     = head.neg;
        cur[0].s       = head.s;
        cur[0].m       = head.m;
        cur[0].du      = head.du;
        cur[0].rem     = head.fr;
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_link
        assign cur[k] = pipe_reg[k-1];
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        if (k < F)
        begin : g_div
            // One quotient bit per stage, most significant first.
            logic [FW:0] rem2;
            always_comb
            begin
                nxt[k] = cur[k];
                rem2   = {cur[k].rem, 1'b0};
                if (rem2 >= {1'b0, cur[k].du})
                begin
                    nxt[k].rem      = FW'(rem2 - {1'b0, cur[k].du});
                    nxt[k].q[F-1-k] = 1'b1;
                end
                else
                begin
                    nxt[k].rem = rem2[FW-1:0];
                end
            end
        end
        else if (k == F)
        begin : g_base
            logic [F:0] t;
            always_comb
            begin
                nxt[k] = cur[k];
                t      = cur[k].ge ? ONE : {1'b0, cur[k].q};
                nxt[k].low = !cur[k].ge && !cur[k].q[F-1];
                unique case (cur[k].kind)
                    ecint_pkg::KIND_OUT:
                        nxt[k].x = ONE - t;
                    ecint_pkg::KIND_INOUT:
                        nxt[k].x = nxt[k].low ? (t << 1) : ((ONE - t) << 1);
                    default:
                        nxt[k].x = t;
                endcase
                nxt[k].p = nxt[k].x;
            end
        end
        else if (k <= F + 4)
        begin : g_pow
            logic [2*F+1:0] prod;
            always_comb
            begin
                nxt[k] = cur[k];
                prod   = cur[k].p * cur[k].x;
                if (3'(k - F) < cur[k].n)
                begin
                    nxt[k].p = prod[2*F:F];
                end
            end
        end
        else if (k == F + 5)
        begin : g_shape
            always_comb
            begin
                nxt[k] = cur[k];
                unique case (cur[k].kind)
                    ecint_pkg::KIND_OUT:
                        nxt[k].f = ONE - cur[k].p;
                    ecint_pkg::KIND_INOUT:
                        nxt[k].f = cur[k].low ? (cur[k].p >> 1) : (ONE - (cur[k].p >> 1));
                    default:
                        nxt[k].f = cur[k].p;
                endcase
            end
        end
        else if (k == F + 6)
        begin : g_mul
            always_comb
            begin
                nxt[k]    = cur[k];
                nxt[k].hi = cur[k].m[V:F] * cur[k].f;
                nxt[k].lo = cur[k].m[F-1:0] * cur[k].f;
            end
        end
        else if (k == F + 7)
        begin : g_mag
            always_comb
            begin
                nxt[k]     = cur[k];
                nxt[k].mag = cur[k].hi[V:0] + (V+1)'(cur[k].lo[2*F:F]);
            end
        end
        else
        begin : g_sum
            always_comb
            begin
                nxt[k]     = cur[k];
                nxt[k].res = cur[k].neg ? (cur[k].s - cur[k].mag[V-1:0])
                                        : (cur[k].s + cur[k].mag[V-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NS-2:0], head_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NS; i++)
            begin
                pipe_reg[i] <= nxt[i];
            end
        end
    end

    assign out_valid   = vld_reg[NS-1];
    assign out_value   = pipe_reg[NS-1].res;
    assign out_clamped = pipe_reg[NS-1].clamped;

endmodule

@@ hw/rtl/easing_curve_interpolator_top.sv @@
// Throughput: one beat per cycle unless a result beat is held at the output, set by the
// fully pipelined one-bit-per-stage divider.
// A four-entry queue lets input beats keep arriving while a result beat is held.
// Reset: rst_n is asynchronous and active low; it empties the queue and the pipe.
// ----------------------------------------------------------------------------
// Easing curve interpolator top level
// Evaluates linear, ease-in, ease-out and ease-in-out curves in fixed point.
// ----------------------------------------------------------------------------
`include "easing_curve_interpolator_top_defines.svh"

module easing_curve_interpolator_top #(
    parameter int VALUE_BITS    = ecint_pkg::VALUE_BITS_DEF,
    parameter int FRAME_BITS    = ecint_pkg::FRAME_BITS_DEF,
    parameter int FRACTION_BITS = ecint_pkg::FRACTION_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // start_value, end_value, frame_number, duration, zero fill to bytes
    input  logic [((2*VALUE_BITS+2*FRAME_BITS+7)/8)*8-1:0] s_tdata,
    // mode
    input  logic [3:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // value, zero fill to bytes
    output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata,
    // frame_clamped
    output logic [0:0] m_tuser
);

    localparam int IN_W   = ((2*VALUE_BITS+2*FRAME_BITS+7)/8)*8;
    localparam int OUT_W  = ((VALUE_BITS+7)/8)*8;
    localparam int ITEM_W = 8 + VALUE_BITS + (VALUE_BITS+1) + 2*FRAME_BITS;

    logic                  push;
    logic [ITEM_W-1:0]     push_item;
    logic                  full;
    logic                  pop;
    logic                  head_valid;
    logic [ITEM_W-1:0]     head_item;
    logic [VALUE_BITS-1:0] out_value;

    ecint_front #(
        .VALUE_BITS   (VALUE_BITS),
        .FRAME_BITS   (FRAME_BITS),
        .IN_BYTES_BITS(IN_W),
        .ITEM_BITS    (ITEM_W)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_item(push_item),
        .full     (full)
    );

    ecint_queue #(
        .WIDTH(ITEM_W),
        .DEPTH(ecint_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_item (head_item)
    );

    ecint_back #(
        .VALUE_BITS   (VALUE_BITS),
        .FRAME_BITS   (FRAME_BITS),
        .FRACTION_BITS(FRACTION_BITS),
        .ITEM_BITS    (ITEM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_clamped(m_tuser[0])
    );

    assign m_tdata = OUT_W'(out_value);

    // An accepted beat is waiting in the queue on the next cycle.
    `ECINT_ASSERT_NEXT(a_push_lands, clk, rst_n, s_tvalid && s_tready, head_valid)
    // With nothing held at the output, a queued beat always moves into the pipe.
    `ECINT_ASSERT_SAME(a_no_idle_stall, clk, rst_n, head_valid && !m_tvalid, pop)
    // The front never accepts a beat while the queue is full.
    `ECINT_ASSERT_SAME(a_no_overflow, clk, rst_n, full, !push)

endmodule

@@ tb/easing_curve_interpolator_checker.sv @@
// ----------------------------------------------------------------------------
// Easing curve interpolator checker
// Watches both stream channels, predicts each result beat from the accepted
// input beat and compares value and clamp flag in order of arrival.
// ----------------------------------------------------------------------------
module easing_curve_interpolator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          mismatches,
    output int          pending
);

    localparam logic [16:0] UNIT = 17'h10000;

    typedef struct packed {
        logic [31:0] value;
        logic        clamped;
    } eased_t;

    eased_t eased_q[$];
    int     results_seen;

    function automatic logic [63:0] raise(logic [63:0] x, int n);
        logic [63:0] p;
        p = x;
        for (int i = 1; i < n; i++)
            p = (p * x) >> 16;
        return p;
    endfunction

    function automatic logic [63:0] shape(logic [3:0] mode, logic [63:0] t);
        logic [63:0] u;
        if (mode >= ecint_pkg::MODE_IN_FIRST && mode <= ecint_pkg::MODE_IN_LAST)
            return raise(t, mode + 1);
        if (mode >= ecint_pkg::MODE_OUT_FIRST && mode <= ecint_pkg::MODE_OUT_LAST)
            return UNIT - raise(UNIT - t, mode - 3);
        if (mode >= ecint_pkg::MODE_INOUT_FIRST && mode <= ecint_pkg::MODE_INOUT_LAST)
        begin
            if (t < (UNIT >> 1))
                return raise(t << 1, mode - 7) >> 1;
            u = (UNIT - t) << 1;
            return UNIT - (raise(u, mode - 7) >> 1);
        end
        return t;
    endfunction

    function automatic eased_t ease(logic [95:0] d, logic [3:0] mode);
        eased_t      r;
        logic [63:0] s, e, diff, m, t, f, mag;
        logic [15:0] fr, du;
        s    = {{32{d[31]}}, d[31:0]};
        e    = {{32{d[63]}}, d[63:32]};
        fr   = d[79:64];
        du   = d[95:80];
        if (fr >= du)
            t = UNIT;
        else
            t = ({48'd0, fr} << 16) / du;
        f    = shape(mode, t);
        diff = e - s;
        m    = diff[63] ? -diff : diff;
        mag  = (m >> 16) * f + (((m & 64'hffff) * f) >> 16);
        r.value   = diff[63] ? 32'(s - mag) : 32'(s + mag);
        r.clamped = fr > du;
        return r;
    endfunction

    always @(posedge clk)
    begin
        eased_t exp_r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                eased_q.push_back(ease(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (eased_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: unexpected result beat value=%h", m_tdata);
                end
                else
                begin
                    exp_r = eased_q.pop_front();
                    if (exp_r.value !== m_tdata || exp_r.clamped !== m_tuser[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("checker: beat %0d expected value=%h clamp=%b, got %h %b",
                                     results_seen, exp_r.value, exp_r.clamped, m_tdata,
                                     m_tuser[0]);
                    end
                end
            end
        end
        pending = eased_q.size();
    end
endmodule

@@ tb/tb_easing_curve_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// Easing curve interpolator testbench
// Drives directed and random curve requests under varying back pressure and
// lets the checker compare every result beat against its own prediction.
// ----------------------------------------------------------------------------
module tb_easing_curve_interpolator_top;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    int          mismatches;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          beats_sent;
    int          idle_cycles;

    easing_curve_interpolator_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    easing_curve_interpolator_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: counts cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_easing_curve_interpolator_top: done, errors");
            $finish;
        end
    end

    task automatic send_request(logic [3:0] mode, logic [31:0] sv, logic [31:0] ev,
                                logic [15:0] fr, logic [15:0] du);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {du, fr, ev, sv};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return $urandom_range(65535) << 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        logic [15:0] du;
        logic [15:0] fr;
        case ($urandom_range(4))
            0: du = 16'($urandom_range(1, 16));
            1: du = 16'hffff;
            default: du = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(5))
            0: fr = du;
            1: fr = du + 16'($urandom_range(1, 200));
            2: fr = 16'($urandom);
            3: fr = du >> 1;
            default: fr = (du == 0) ? 16'd0 : 16'($urandom_range(du));
        endcase
        send_request(4'($urandom), random_value(), random_value(), fr, du);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        beats_sent    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every mode once at mid transition, then field extremes and the
        // frame-at, frame-past and zero-duration cases.
        for (int m = 0; m < 16; m++)
            send_request(4'(m), 32'hfff0_0000, 32'h0020_0000, 16'd3, 16'd8);
        send_request(ecint_pkg::MODE_IN_FIRST, 32'h8000_0000, 32'h7fff_ffff, 16'd1, 16'hffff);
        send_request(ecint_pkg::MODE_OUT_LAST, 32'h7fff_ffff, 32'h8000_0000, 16'hfffe,
                     16'hffff);
        send_request(ecint_pkg::MODE_INOUT_LAST, 32'h0, 32'h0001_0000, 16'd100, 16'd100);
        send_request(ecint_pkg::MODE_INOUT_FIRST, 32'h1234_5678, 32'h8765_4321, 16'hffff,
                     16'd9);
        send_request(4'd0, 32'h0, 32'h7fff_ffff, 16'd0, 16'd0);
        send_request(4'd15, 32'h5555_aaaa, 32'haaaa_5555, 16'd5, 16'd0);
        send_request(ecint_pkg::MODE_INOUT_LAST, 32'hffff_ffff, 32'h0, 16'd0, 16'hffff);
        drain();

        send_idle_pct = 33;
        recv_idle_pct = 84;
        repeat (150) random_request();
        // Hold the sender until every outstanding result has arrived.
        drain();
        send_idle_pct = 84;
        recv_idle_pct = 33;
        repeat (150) random_request();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (150) random_request();
        drain();

        $display("Sent %0d beats: all 16 modes, value and frame extremes, clamped and", beats_sent);
        $display("zero-duration frames, under three mixes of input and output stalls.");
        if (mismatches == 0)
            $display("tb_easing_curve_interpolator_top: done, clean");
        else
            $display("tb_easing_curve_interpolator_top: done, errors");
        $finish;
    end
endmodule
